[sv/rsp_pkg.sv]
// -----------------------------------------------------------------------------
// rsp_pkg: shared types and constants for rectangle piece subtraction
// Coordinate widths, piece kind codes and the descriptor that the
// classify front hands to the emit back through the work queue.
// -----------------------------------------------------------------------------
package rsp_pkg;

  localparam int COORD_BITS     = 16;
  localparam int SIZE_BITS      = COORD_BITS - 1;
  localparam int EXT_BITS       = COORD_BITS + 1;
  localparam int NUM_KINDS      = 6;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  // piece kind codes; the same value is the bit index in a piece mask
  typedef enum logic [2:0] {
    KIND_UNCHANGED = 3'd0,
    KIND_TOP       = 3'd1,
    KIND_LEFT      = 3'd2,
    KIND_RIGHT     = 3'd3,
    KIND_BOTTOM    = 3'd4,
    KIND_COVERED   = 3'd5
  } kind_t;

  typedef logic [NUM_KINDS-1:0] piece_mask_t;

  // one classified item: bottom rectangle, edges needed to cut it,
  // and the set of pieces still to emit
  typedef struct packed {
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic        [SIZE_BITS-1:0]  bw;
    logic        [SIZE_BITS-1:0]  bh;
    logic signed [COORD_BITS-1:0] tx;
    logic signed [COORD_BITS-1:0] ty;
    logic signed [EXT_BITS-1:0]   tr;
    logic signed [EXT_BITS-1:0]   tb;
    logic signed [EXT_BITS-1:0]   br;
    logic signed [EXT_BITS-1:0]   bb;
    logic signed [COORD_BITS-1:0] my;
    logic signed [EXT_BITS-1:0]   mb;
    piece_mask_t                  mask;
  } rsp_desc_t;

endpackage

[sv/rectangle_subtract_pieces.sv]
// -----------------------------------------------------------------------------
// rectangle_subtract_pieces: visible pieces of a covered rectangle
// Top level: classify front, work queue and piece emitter.
// -----------------------------------------------------------------------------
// Each beat on the input carries a covering (top) and a covered (bottom)
// rectangle; the block returns the parts of the bottom one left visible.
// With no strict overlap it returns the bottom rectangle unchanged (kind 0);
// when fully hidden it returns one covered marker (kind 5, geometry zero);
// otherwise it returns up to four pieces in the order top, left, right,
// bottom, top and bottom spanning the full width, left and right spanning
// the vertical overlap. The final result of each input beat has last set.
// Both sides look like queues: push/full in, empty/pop out. The front
// classifies an item in the cycle it is pushed and files it into a
// four-entry work queue; the emitter drains one piece per cycle into an
// output register while that register is empty or its result is popped,
// so an item that yields n results (1 to 4) holds the emitter until its
// last piece leaves, and the emitter's output of pieces sets the sustained
// intake rate. The first result of an item passes through the work queue,
// the emitter's current-descriptor register and the output register.
// -----------------------------------------------------------------------------
module rectangle_subtract_pieces
  import rsp_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] top_x,
  input  logic signed [COORD_BITS-1:0] top_y,
  input  logic        [SIZE_BITS-1:0]  top_w,
  input  logic        [SIZE_BITS-1:0]  top_h,
  input  logic signed [COORD_BITS-1:0] bottom_x,
  input  logic signed [COORD_BITS-1:0] bottom_y,
  input  logic        [SIZE_BITS-1:0]  bottom_w,
  input  logic        [SIZE_BITS-1:0]  bottom_h,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [COORD_BITS-1:0] piece_x,
  output logic signed [COORD_BITS-1:0] piece_y,
  output logic        [SIZE_BITS-1:0]  piece_w,
  output logic        [SIZE_BITS-1:0]  piece_h,
  output logic        [2:0]            piece_kind,
  output logic                         last
);

  rsp_desc_t desc_in;
  rsp_desc_t desc_out;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;
  logic      out_valid;
  kind_t     kind;

  // classify the incoming beat in the cycle it arrives
  rsp_classify u_classify (
    .top_x    (top_x),
    .top_y    (top_y),
    .top_w    (top_w),
    .top_h    (top_h),
    .bottom_x (bottom_x),
    .bottom_y (bottom_y),
    .bottom_w (bottom_w),
    .bottom_h (bottom_h),
    .desc     (desc_in)
  );

  // hold classified items until the emitter is free
  rsp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push && !q_full),
    .wr_data (desc_in),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (desc_out),
    .empty   (q_empty)
  );

  // advance one piece per cycle into the output register while it is empty or popped
  rsp_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_data     (desc_out),
    .q_pop      (q_pop),
    .piece_x    (piece_x),
    .piece_y    (piece_y),
    .piece_w    (piece_w),
    .piece_h    (piece_h),
    .piece_kind (kind),
    .last       (last),
    .out_valid  (out_valid),
    .pop        (pop)
  );

  assign full       = q_full;
  assign empty      = !out_valid;
  assign piece_kind = kind;

endmodule

[sv/rsp_classify.sv]
// -----------------------------------------------------------------------------
// rsp_classify: overlap test and piece selection
// Forms the far edges with one extra bit, tests overlap strictly and
// builds the descriptor with the mask of pieces to emit.
// -----------------------------------------------------------------------------
module rsp_classify
  import rsp_pkg::*;
(
  input  logic signed [COORD_BITS-1:0] top_x,
  input  logic signed [COORD_BITS-1:0] top_y,
  input  logic        [SIZE_BITS-1:0]  top_w,
  input  logic        [SIZE_BITS-1:0]  top_h,
  input  logic signed [COORD_BITS-1:0] bottom_x,
  input  logic signed [COORD_BITS-1:0] bottom_y,
  input  logic        [SIZE_BITS-1:0]  bottom_w,
  input  logic        [SIZE_BITS-1:0]  bottom_h,
  output rsp_desc_t                    desc
);

  logic signed [EXT_BITS-1:0] tx_e, ty_e, bx_e, by_e;
  logic signed [EXT_BITS-1:0] tr, tb, br, bb;
  logic overlap, has_top, has_left, has_right, has_bottom;

  assign tx_e = {top_x[COORD_BITS-1], top_x};
  assign ty_e = {top_y[COORD_BITS-1], top_y};
  assign bx_e = {bottom_x[COORD_BITS-1], bottom_x};
  assign by_e = {bottom_y[COORD_BITS-1], bottom_y};

  assign tr = tx_e + $signed({2'b00, top_w});
  assign tb = ty_e + $signed({2'b00, top_h});
  assign br = bx_e + $signed({2'b00, bottom_w});
  assign bb = by_e + $signed({2'b00, bottom_h});

  assign overlap    = (tx_e < br) && (tr > bx_e) && (ty_e < bb) && (tb > by_e);
  assign has_top    = top_y > bottom_y;
  assign has_left   = top_x > bottom_x;
  assign has_right  = tr < br;
  assign has_bottom = tb < bb;

  always_comb begin
    desc.bx = bottom_x;
    desc.by = bottom_y;
    desc.bw = bottom_w;
    desc.bh = bottom_h;
    desc.tx = top_x;
    desc.ty = top_y;
    desc.tr = tr;
    desc.tb = tb;
    desc.br = br;
    desc.bb = bb;
    desc.my = (bottom_y > top_y) ? bottom_y : top_y;
    desc.mb = (bb < tb) ? bb : tb;
    desc.mask = '0;
    if (!overlap) begin
      desc.mask[KIND_UNCHANGED] = 1'b1;
    end else if (!(has_top || has_left || has_right || has_bottom)) begin
      desc.mask[KIND_COVERED] = 1'b1;
    end else begin
      desc.mask[KIND_TOP]    = has_top;
      desc.mask[KIND_LEFT]   = has_left;
      desc.mask[KIND_RIGHT]  = has_right;
      desc.mask[KIND_BOTTOM] = has_bottom;
    end
  end

endmodule

[sv/rsp_queue.sv]
// -----------------------------------------------------------------------------
// rsp_queue: work queue between classify front and emit back
// Small first-in first-out store of classified descriptors.
// -----------------------------------------------------------------------------
module rsp_queue
  import rsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  rsp_desc_t wr_data,
  output logic      full,
  input  logic      rd_en,
  output rsp_desc_t rd_data,
  output logic      empty
);

  localparam logic [QUEUE_PTR_BITS:0]   FULL_COUNT = (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH);
  localparam logic [QUEUE_PTR_BITS-1:0] LAST_PTR   = QUEUE_PTR_BITS'(QUEUE_DEPTH - 1);

  rsp_desc_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_PTR_BITS:0]   count;

  assign full    = count == FULL_COUNT;
  assign empty   = count == '0;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[sv/rsp_emit.sv]
// -----------------------------------------------------------------------------
// rsp_emit: piece emitter
// Takes one descriptor at a time and emits its pieces in kind order,
// one per cycle while the output register is empty or being popped.
// -----------------------------------------------------------------------------
module rsp_emit
  import rsp_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  rsp_desc_t                    q_data,
  output logic                         q_pop,
  output logic signed [COORD_BITS-1:0] piece_x,
  output logic signed [COORD_BITS-1:0] piece_y,
  output logic        [SIZE_BITS-1:0]  piece_w,
  output logic        [SIZE_BITS-1:0]  piece_h,
  output kind_t                        piece_kind,
  output logic                         last,
  output logic                         out_valid,
  input  logic                         pop
);

  rsp_desc_t   cur;
  logic        cur_valid;
  piece_mask_t rem;
  piece_mask_t pick;
  piece_mask_t rem_left;
  logic        out_load;
  logic        done;

  logic signed [EXT_BITS-1:0]   bx_e, by_e, tx_e, ty_e, my_e;
  logic signed [COORD_BITS-1:0] x_next, y_next;
  logic        [SIZE_BITS-1:0]  w_next, h_next;
  logic signed [EXT_BITS-1:0]   w_diff, h_diff;
  kind_t                        kind_next;

  assign pick     = rem & (~rem + 1'b1);
  assign rem_left = rem & ~pick;
  assign out_load = cur_valid && (!out_valid || pop);
  assign done     = out_load && (rem_left == '0);
  assign q_pop    = !q_empty && (!cur_valid || done);

  assign bx_e = {cur.bx[COORD_BITS-1], cur.bx};
  assign by_e = {cur.by[COORD_BITS-1], cur.by};
  assign tx_e = {cur.tx[COORD_BITS-1], cur.tx};
  assign ty_e = {cur.ty[COORD_BITS-1], cur.ty};
  assign my_e = {cur.my[COORD_BITS-1], cur.my};

  // geometry of the selected piece
  always_comb begin
    x_next    = cur.bx;
    y_next    = cur.by;
    w_diff    = $signed({2'b00, cur.bw});
    h_diff    = $signed({2'b00, cur.bh});
    kind_next = KIND_UNCHANGED;
    case (1'b1)
      pick[KIND_TOP]: begin
        h_diff    = ty_e - by_e;
        kind_next = KIND_TOP;
      end
      pick[KIND_LEFT]: begin
        y_next    = cur.my;
        w_diff    = tx_e - bx_e;
        h_diff    = cur.mb - my_e;
        kind_next = KIND_LEFT;
      end
      pick[KIND_RIGHT]: begin
        x_next    = cur.tr[COORD_BITS-1:0];
        y_next    = cur.my;
        w_diff    = cur.br - cur.tr;
        h_diff    = cur.mb - my_e;
        kind_next = KIND_RIGHT;
      end
      pick[KIND_BOTTOM]: begin
        y_next    = cur.tb[COORD_BITS-1:0];
        h_diff    = cur.bb - cur.tb;
        kind_next = KIND_BOTTOM;
      end
      pick[KIND_COVERED]: begin
        x_next    = '0;
        y_next    = '0;
        w_diff    = '0;
        h_diff    = '0;
        kind_next = KIND_COVERED;
      end
      default: begin
        kind_next = KIND_UNCHANGED;
      end
    endcase
    w_next = w_diff[SIZE_BITS-1:0];
    h_next = h_diff[SIZE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
      end else if (done) begin
        cur_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
      rem <= q_data.mask;
    end else if (out_load) begin
      rem <= rem_left;
    end
    if (out_load) begin
      piece_x    <= x_next;
      piece_y    <= y_next;
      piece_w    <= w_next;
      piece_h    <= h_next;
      piece_kind <= kind_next;
      last       <= rem_left == '0;
    end
  end

  a_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> rem != '0)
    else $error("active descriptor has no pieces left");

  a_pick_onehot: assert property (@(posedge clk) disable iff (rst)
    out_load |-> $onehot(pick))
    else $error("piece select is not one-hot");

  a_single_kinds: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && (rem[KIND_UNCHANGED] || rem[KIND_COVERED])) |-> $onehot(rem))
    else $error("unchanged or covered result mixed with other pieces");

  a_no_refill_busy: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && !done) |-> !q_pop)
    else $error("descriptor replaced before its last piece left");

endmodule
